[rtl/core/assert_macros.svh]
// Assertion macros used by the port-level checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/core/wtsm_pkg.sv]
// Package for the weekly time slot matcher: sizes, slot and result types.
// No dependencies.
package wtsm_pkg;

    localparam int SLOT_COUNT  = 8;
    localparam int SLOT_IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int COUNT_W     = 5;
    localparam int MAP_W       = 16;
    localparam int MAP_IDX_W   = 4;
    localparam int IN_DATA_W   = 80;
    localparam int OUT_DATA_W  = 64;

    localparam logic [17:0] DAY_SECONDS = 18'd86400;
    localparam logic [2:0]  WEEK_DAYS   = 3'd7;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_DISABLE = 2'd1,
        OP_QUERY   = 2'd2,
        OP_OVERLAP = 2'd3
    } op_t;

    typedef struct packed {
        logic        on;
        logic [6:0]  mask;
        logic [16:0] lo;
        logic [17:0] hi;
        logic [7:0]  val;
    } slot_t;

    // query context handed to the evaluator
    typedef struct packed {
        logic [16:0] now;
        logic [2:0]  wd;
        logic [6:0]  days;
        logic [16:0] cand_lo;
        logic [17:0] cand_hi;
    } query_t;

    typedef struct packed {
        logic                  valid;
        logic [SLOT_IDX_W-1:0] idx;
        logic                  on;
        logic                  act;
        logic                  hit;
        logic [20:0]           span;
        logic [7:0]            val;
        logic [17:0]           hi;
    } eval_t;

    typedef struct packed {
        logic        index_error;
        logic [3:0]  first_free_index;
        logic        free_found;
        logic [4:0]  overlap_count;
        logic [15:0] active_map;
        logic [17:0] remaining_seconds;
        logic [7:0]  active_value;
        logic [3:0]  active_index;
        logic        found;
    } result_t;

endpackage

[rtl/core/wtsm_slot_table.sv]
// Slot table storage: one write port, one read port, cleared at reset.
// Depends on wtsm_pkg.
module wtsm_slot_table
    import wtsm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic                  wr_disable,
    input  logic [SLOT_IDX_W-1:0] wr_idx,
    input  slot_t                 wr_slot,
    input  logic [SLOT_IDX_W-1:0] rd_idx,
    output slot_t                 rd_slot
);

    slot_t table_reg [SLOT_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                table_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            if (wr_disable)
            begin
                table_reg[wr_idx].on <= 1'b0;
            end
            else
            begin
                table_reg[wr_idx] <= wr_slot;
            end
        end
    end

    assign rd_slot = table_reg[rd_idx];

endmodule

[rtl/core/wtsm_slot_eval.sv]
// Shared slot evaluator: coverage, weekly span and overlap test for one slot a cycle.
// Depends on wtsm_pkg.
module wtsm_slot_eval
    import wtsm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [SLOT_IDX_W-1:0] in_idx,
    input  slot_t                 slot,
    input  query_t                qry,
    output eval_t                 ev
);

    eval_t       ev_reg;
    eval_t       ev_next;
    logic        day_ok;
    logic [2:0]  n_days;
    logic [17:0] dur;
    logic [17:0] lo_x;
    logic [17:0] now_x;
    logic [17:0] clo_x;

    always_comb
    begin
        lo_x   = {1'b0, slot.lo};
        now_x  = {1'b0, qry.now};
        clo_x  = {1'b0, qry.cand_lo};
        day_ok = (qry.wd < WEEK_DAYS) && slot.mask[qry.wd];
        n_days = 3'd0;
        for (int d = 0; d < 7; d++)
        begin
            n_days = n_days + {2'b00, slot.mask[d]};
        end
        dur = (lo_x < slot.hi) ? (slot.hi - lo_x) : (lo_x - slot.hi);

        ev_next       = '0;
        ev_next.valid = in_valid;
        ev_next.idx   = in_idx;
        ev_next.on    = slot.on;
        ev_next.val   = slot.val;
        ev_next.hi    = slot.hi;
        ev_next.span  = 21'(dur) * 21'(n_days);
        if (slot.hi > DAY_SECONDS)
        begin
            ev_next.act = day_ok && ((now_x < (slot.hi - DAY_SECONDS))
                                     || (now_x >= lo_x && now_x < DAY_SECONDS));
        end
        else
        begin
            ev_next.act = day_ok && (now_x >= lo_x) && (now_x < slot.hi);
        end
        ev_next.hit = ((slot.mask & qry.days) != 7'd0)
                   && ((clo_x >= lo_x && clo_x <= slot.hi)
                    || (qry.cand_hi >= lo_x && qry.cand_hi <= slot.hi)
                    || (lo_x >= clo_x && lo_x <= qry.cand_hi)
                    || (slot.hi >= clo_x && slot.hi <= qry.cand_hi));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_reg <= '0;
        end
        else
        begin
            ev_reg <= ev_next;
        end
    end

    assign ev = ev_reg;

endmodule

[rtl/core/weekly_time_slot_matcher.sv]
// Top level of the weekly time slot matcher: sequencer, accumulators, stream ports.
// Depends on wtsm_pkg, wtsm_slot_table and wtsm_slot_eval.
//
// Write and disable go from acceptance straight to the finish state; query and
// overlap count pass through the scan, drain and finish states, because a single
// evaluator looks at one slot per cycle, followed by a pipeline drain state and a
// result state. s_tready is low while a transaction is in progress; a finished
// result waits in the output register until taken.
module weekly_time_slot_matcher
    import wtsm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // opcode, slot_idx, enabled, days, start_sec, end_sec, slot_value,
    // weekday, hour, minute, second, zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // found, active_index, active_value, remaining_seconds, active_map,
    // overlap_count, free_found, first_free_index, index_error, zero pad
    output logic [OUT_DATA_W-1:0] m_tdata
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]  in_op;
    logic [3:0]  in_idx;
    logic        in_en;
    logic [6:0]  in_days;
    logic [16:0] in_st;
    logic [17:0] in_ed;
    logic [7:0]  in_val;
    logic [2:0]  in_wd;
    logic [4:0]  in_hr;
    logic [5:0]  in_mn;
    logic [5:0]  in_sc;

    assign in_op   = s_tdata[1:0];
    assign in_idx  = s_tdata[5:2];
    assign in_en   = s_tdata[6];
    assign in_days = s_tdata[13:7];
    assign in_st   = s_tdata[30:14];
    assign in_ed   = s_tdata[48:31];
    assign in_val  = s_tdata[56:49];
    assign in_wd   = s_tdata[59:57];
    assign in_hr   = s_tdata[64:60];
    assign in_mn   = s_tdata[70:65];
    assign in_sc   = s_tdata[76:71];

    logic in_fire;
    logic idx_bad;
    logic out_free;

    assign in_fire  = s_tvalid && s_tready;
    assign idx_bad  = {1'b0, in_idx} >= 5'(SLOT_COUNT);
    assign out_free = !m_tvalid || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    op_t                   op_reg;
    logic                  err_reg;
    query_t                qry_reg;
    logic [SLOT_IDX_W-1:0] scan_reg, scan_next;

    slot_t rd_slot;
    slot_t wr_slot;
    eval_t ev;

    assign wr_slot = '{on: in_en, mask: in_days, lo: in_st, hi: in_ed, val: in_val};

    wtsm_slot_table u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (in_fire && !idx_bad && (in_op == OP_WRITE || in_op == OP_DISABLE)),
        .wr_disable (in_op == OP_DISABLE),
        .wr_idx     (in_idx[SLOT_IDX_W-1:0]),
        .wr_slot    (wr_slot),
        .rd_idx     (scan_reg),
        .rd_slot    (rd_slot)
    );

    wtsm_slot_eval u_eval (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (state_reg == ST_SCAN),
        .in_idx   (scan_reg),
        .slot     (rd_slot),
        .qry      (qry_reg),
        .ev       (ev)
    );

    // accumulators
    logic                  got_reg;
    logic [20:0]           best_reg;
    logic [7:0]            bval_reg;
    logic [SLOT_IDX_W-1:0] bidx_reg;
    logic [17:0]           bhi_reg;
    logic                  free_reg;
    logic [SLOT_IDX_W-1:0] fidx_reg;
    logic [MAP_W-1:0]      map_reg;
    logic [COUNT_W-1:0]    cnt_reg;
    logic                  take;

    assign take = ev.valid && ev.on && ev.act
               && (!got_reg || ev.span < best_reg
                   || (ev.span == best_reg && ev.val > bval_reg));

    always_comb
    begin
        state_next = state_reg;
        scan_next  = scan_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                scan_next = '0;
                if (in_fire)
                begin
                    if (in_op == OP_QUERY || in_op == OP_OVERLAP)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_reg == SLOT_IDX_W'(SLOT_COUNT - 1))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            scan_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            scan_reg  <= scan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg          <= op_t'(in_op);
            err_reg         <= idx_bad;
            qry_reg.now     <= 17'(in_hr) * 17'd3600 + 17'(in_mn) * 17'd60 + 17'(in_sc);
            qry_reg.wd      <= in_wd;
            qry_reg.days    <= in_days;
            qry_reg.cand_lo <= in_st;
            qry_reg.cand_hi <= in_ed;
            got_reg         <= 1'b0;
            best_reg        <= '0;
            bval_reg        <= '0;
            bidx_reg        <= '0;
            bhi_reg         <= '0;
            free_reg        <= 1'b0;
            fidx_reg        <= '0;
            map_reg         <= '0;
            cnt_reg         <= '0;
        end
        else if (ev.valid)
        begin
            if (ev.act)
            begin
                map_reg[MAP_IDX_W'(ev.idx)] <= 1'b1;
            end
            if (!ev.on && !free_reg)
            begin
                free_reg <= 1'b1;
                fidx_reg <= ev.idx;
            end
            if (take)
            begin
                got_reg  <= 1'b1;
                best_reg <= ev.span;
                bval_reg <= ev.val;
                bidx_reg <= ev.idx;
                bhi_reg  <= ev.hi;
            end
            if (ev.on && ev.hit)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    result_t res;

    always_comb
    begin
        res = '0;
        unique case (op_reg)
            OP_WRITE, OP_DISABLE:
            begin
                res.index_error = err_reg;
            end
            OP_QUERY:
            begin
                if (got_reg)
                begin
                    res.found             = 1'b1;
                    res.active_index      = 4'(bidx_reg);
                    res.active_value      = bval_reg;
                    res.remaining_seconds = bhi_reg - {1'b0, qry_reg.now};
                end
                res.active_map       = map_reg;
                res.free_found       = free_reg;
                res.first_free_index = 4'(fidx_reg);
            end
            OP_OVERLAP:
            begin
                res.overlap_count = cnt_reg;
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (state_reg == ST_FINISH && out_free)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FINISH && out_free)
        begin
            m_tdata_reg <= OUT_DATA_W'(res);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[rtl/core/wtsm_checker.sv]
// Port-level checker for the weekly time slot matcher, bound to the top level.
// Depends on wtsm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wtsm_checker
    import wtsm_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [IN_DATA_W-1:0]  s_tdata,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready)
    `ASSERT_IMPL(a_not_found_zero, clk, rst_n, m_tvalid && !m_tdata[0], m_tdata[30:1] == 30'd0)
    `ASSERT_IMPL(a_err_alone, clk, rst_n, m_tvalid && m_tdata[57], m_tdata[56:0] == 57'd0)

endmodule

bind weekly_time_slot_matcher wtsm_checker u_wtsm_checker (.*);
